// ===== src/wmm_pkg.sv =====
`timescale 1ns / 1ps

package wmm_pkg;

    localparam int TIME_W      = 32;
    localparam int SAMPLE_W    = 16;
    localparam int BATCH_DEPTH = 4;
    localparam int CNT_W       = $clog2(BATCH_DEPTH + 1);

    localparam logic [TIME_W-1:0] WIDTH_RESET = TIME_W'(1000);

    typedef struct packed {
        logic [TIME_W-1:0]          sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic                       last_sample;
    } t_sample;

    typedef struct packed {
        logic [TIME_W-1:0]          window_start;
        logic signed [SAMPLE_W-1:0] peak_value;
        logic                       is_max;
        logic                       run_last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]              count;
        t_result [BATCH_DEPTH-1:0]     item;
    } t_batch;

endpackage

// ===== src/wmm_core.sv =====
`timescale 1ns / 1ps

module wmm_core import wmm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_sample           i_in_data,
    input  logic              i_cfg_valid,
    input  logic [TIME_W-1:0] i_cfg_data,
    input  logic              i_load_ok,
    output logic              o_load,
    output t_batch            o_batch
);

    logic                       r_in_valid;
    t_sample                    r_in;
    logic [TIME_W-1:0]          r_width;
    logic                       r_open;
    logic [TIME_W-1:0]          r_start;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;

    logic                       n_open;
    logic [TIME_W-1:0]          n_start;
    logic signed [SAMPLE_W-1:0] n_min;
    logic signed [SAMPLE_W-1:0] n_max;

    logic                       consume;
    logic [TIME_W-1:0]          elapsed;
    logic                       close;
    logic                       last;
    logic signed [SAMPLE_W-1:0] y;
    t_result                    a_min, a_max, b_min, b_max;

    assign consume    = r_in_valid && i_load_ok;
    assign o_in_ready = !r_in_valid || consume;
    assign o_load     = consume;

    assign y       = r_in.sample_y;
    assign last    = r_in.last_sample;
    assign elapsed = r_in.sample_x - r_start;
    assign close   = r_open && (elapsed >= r_width);

    always_comb begin
        if (!r_open || close) begin
            n_start = r_in.sample_x;
            n_min   = y;
            n_max   = y;
        end else begin
            n_start = r_start;
            n_min   = (y < r_min) ? y : r_min;
            n_max   = (y > r_max) ? y : r_max;
        end
        n_open = !last;

        a_min = '{window_start: r_start, peak_value: r_min, is_max: 1'b0, run_last: 1'b0};
        a_max = '{window_start: r_start, peak_value: r_max, is_max: 1'b1, run_last: 1'b0};
        b_min = '{window_start: n_start, peak_value: n_min, is_max: 1'b0, run_last: 1'b0};
        b_max = '{window_start: n_start, peak_value: n_max, is_max: 1'b1, run_last: 1'b1};

        o_batch.item[0] = close ? a_min : b_min;
        o_batch.item[1] = close ? a_max : b_max;
        o_batch.item[1].run_last = !(close && last);
        o_batch.item[2] = b_min;
        o_batch.item[3] = b_max;
        o_batch.count   = (close ? CNT_W'(2) : CNT_W'(0)) + (last ? CNT_W'(2) : CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_open     <= 1'b0;
            r_width    <= WIDTH_RESET;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_open <= n_open;
            end
            if (i_cfg_valid) begin
                r_width <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (consume) begin
            r_start <= n_start;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

endmodule

// ===== src/wmm_outbuf.sv =====
`timescale 1ns / 1ps

module wmm_outbuf import wmm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_batch  i_batch,
    output logic    o_load_ok,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    logic [CNT_W-1:0]          r_cnt;
    t_result [BATCH_DEPTH-1:0] r_buf;
    logic                      pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_buf[0];
    assign pop         = o_out_valid && i_out_ready;
    assign o_load_ok   = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.count;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_batch.item;
        end else if (pop) begin
            for (int k = 0; k < BATCH_DEPTH - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

endmodule

// ===== src/window_minmax_downsampler.sv =====
`timescale 1ns / 1ps

// Peak-detecting downsampler. Samples (timestamp, value) enter one per cycle, as the
// result buffer allows, into an input register; a sample that closes a window, or is
// flagged last, emits the window minimum then maximum tagged with the window start
// (up to four results per sample). A sample waits there until the buffer is empty or
// passing its final result; results drain one per cycle while the output is ready.
// Results pass the input register, then the result buffer. window_width resets to 1000;
// the user must write it through the cfg channel while the block is idle (unenforced).

module window_minmax_downsampler import wmm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_sample           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TIME_W-1:0] i_cfg_data
);

    logic   load_ok;
    logic   load;
    t_batch batch;

    assign o_cfg_ready = 1'b1;

    wmm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_load_ok   (load_ok),
        .o_load      (load),
        .o_batch     (batch)
    );

    wmm_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_batch     (batch),
        .o_load_ok   (load_ok),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
